/* design/exyz_pkg.sv */
package exyz_pkg;

    localparam int ANGLE_W = 17;
    localparam int ENTRY_W = 16;
    localparam int TRIG_W = 16;
    localparam int NUM_LANES = 3;
    localparam int CORDIC_STEPS = 16;
    localparam int CX_W = 34;
    localparam int CZ_W = 25;
    localparam int REST_W = 14;
    localparam int QUAD_W = 2;
    localparam int FULL_TURN = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int ONE_Q14 = 16384;
    localparam longint CORDIC_GAIN = 64'd652032874;

    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        t_trig sn;
        t_trig cs;
    } t_sincos;

    function automatic logic signed [CZ_W-1:0] atan_tab(input logic [3:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            4'd0:  v = 25'sd2949120;
            4'd1:  v = 25'sd1740967;
            4'd2:  v = 25'sd919879;
            4'd3:  v = 25'sd466945;
            4'd4:  v = 25'sd234379;
            4'd5:  v = 25'sd117304;
            4'd6:  v = 25'sd58666;
            4'd7:  v = 25'sd29335;
            4'd8:  v = 25'sd14668;
            4'd9:  v = 25'sd7334;
            4'd10: v = 25'sd3667;
            4'd11: v = 25'sd1833;
            4'd12: v = 25'sd917;
            4'd13: v = 25'sd458;
            4'd14: v = 25'sd229;
            default: v = 25'sd115;
        endcase
        return v;
    endfunction

    function automatic t_trig clamp_q14(input logic signed [47:0] v);
        t_trig r;
        if (v > 48'sd16384) begin
            r = 16'sd16384;
        end else if (v < -48'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[TRIG_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/exyz_cordic.sv */
module exyz_cordic
    import exyz_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output t_sincos                   o_sc
);

    // Stage 0: reduce the angle to a quadrant and a rest in 2^-7 degree units.
    logic signed [ANGLE_W+1:0] w_a;
    logic signed [ANGLE_W+1:0] w_r;
    logic [QUAD_W-1:0]         w_q;
    logic [REST_W-1:0]         w_rest;

    always_comb begin
        w_a = {{2{i_angle[ANGLE_W-1]}}, i_angle};
        if (w_a < 0) begin
            w_r = w_a + 19'(FULL_TURN);
        end else if (w_a >= 19'(FULL_TURN)) begin
            w_r = w_a - 19'(FULL_TURN);
        end else begin
            w_r = w_a;
        end
        if (w_r < 0) begin
            w_r = w_r + 19'(FULL_TURN);
        end
        if (w_r >= 19'(3*QUARTER_TURN)) begin
            w_q = QUAD_3;
            w_rest = REST_W'(w_r - 19'(3*QUARTER_TURN));
        end else if (w_r >= 19'(2*QUARTER_TURN)) begin
            w_q = QUAD_2;
            w_rest = REST_W'(w_r - 19'(2*QUARTER_TURN));
        end else if (w_r >= 19'(QUARTER_TURN)) begin
            w_q = QUAD_1;
            w_rest = REST_W'(w_r - 19'(QUARTER_TURN));
        end else begin
            w_q = QUAD_0;
            w_rest = REST_W'(w_r);
        end
    end

    logic signed [CX_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] r_z [CORDIC_STEPS+1];
    logic [QUAD_W-1:0]      r_q [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CX_W'(CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= CZ_W'({w_rest, 9'd0});
            r_q[0] <= w_q;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [CX_W-1:0] w_dx;
        logic signed [CX_W-1:0] w_dy;
        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= r_q[g];
                if (!r_z[g][CZ_W-1]) begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - atan_tab(4'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + atan_tab(4'(g));
                end
            end
        end
    end

    t_trig w_s;
    t_trig w_c;
    t_sincos n_sc;
    logic signed [CX_W-1:0] w_ys;
    logic signed [CX_W-1:0] w_xs;

    always_comb begin
        w_ys = (r_y[CORDIC_STEPS] + CX_W'(32768)) >>> 16;
        w_xs = (r_x[CORDIC_STEPS] + CX_W'(32768)) >>> 16;
        w_s = clamp_q14(48'(w_ys));
        w_c = clamp_q14(48'(w_xs));
        unique case (r_q[CORDIC_STEPS])
            QUAD_0: begin n_sc.sn = w_s;  n_sc.cs = w_c;  end
            QUAD_1: begin n_sc.sn = w_c;  n_sc.cs = -w_s; end
            QUAD_2: begin n_sc.sn = -w_s; n_sc.cs = -w_c; end
            default: begin n_sc.sn = -w_c; n_sc.cs = w_s; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sc <= n_sc;
        end
    end

endmodule

/* design/exyz_merge.sv */
module exyz_merge
    import exyz_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sincos i_scx,
    input  t_sincos i_scy,
    input  t_sincos i_scz,
    output t_trig   o_m [9]
);

    // Stage A: all double products.
    logic signed [31:0] r_cycz, r_cysz, r_sxcy, r_cxcy, r_sxsy, r_cxsy;
    logic signed [31:0] r_cxsz, r_cxcz, r_sxsz, r_sxcz;
    t_trig              r_sy, r_cz, r_sz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= i_scy.cs * i_scz.cs;
            r_cysz <= i_scy.cs * i_scz.sn;
            r_sxcy <= i_scx.sn * i_scy.cs;
            r_cxcy <= i_scx.cs * i_scy.cs;
            r_sxsy <= i_scx.sn * i_scy.sn;
            r_cxsy <= i_scx.cs * i_scy.sn;
            r_cxsz <= i_scx.cs * i_scz.sn;
            r_cxcz <= i_scx.cs * i_scz.cs;
            r_sxsz <= i_scx.sn * i_scz.sn;
            r_sxcz <= i_scx.sn * i_scz.cs;
            r_sy   <= i_scy.sn;
            r_cz   <= i_scz.cs;
            r_sz   <= i_scz.sn;
        end
    end

    // Stage B: triple products, other entries rounded.
    logic signed [47:0] r_t3, r_t4, r_t6, r_t7;
    logic signed [31:0] r_cxsz2, r_cxcz2, r_sxsz2, r_sxcz2;
    t_trig r_e0, r_e1, r_e2, r_e5, r_e8;

    function automatic t_trig rnd28(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = (v + 48'sd8192) >>> 14;
        return clamp_q14(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t3 <= r_sxsy * r_cz;
            r_t4 <= r_sxsy * r_sz;
            r_t6 <= r_cxsy * r_cz;
            r_t7 <= r_cxsy * r_sz;
            r_cxsz2 <= r_cxsz;
            r_cxcz2 <= r_cxcz;
            r_sxsz2 <= r_sxsz;
            r_sxcz2 <= r_sxcz;
            r_e0 <= rnd28(48'(r_cycz));
            r_e1 <= rnd28(-48'(r_cysz));
            r_e2 <= clamp_q14(48'(r_sy));
            r_e5 <= rnd28(-48'(r_sxcy));
            r_e8 <= rnd28(48'(r_cxcy));
        end
    end

    function automatic t_trig rnd42(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = (v + 48'sd134217728) >>> 28;
        return clamp_q14(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m[0] <= r_e0;
            o_m[1] <= r_e1;
            o_m[2] <= r_e2;
            o_m[3] <= rnd42(r_t3 + {{2{r_cxsz2[31]}}, r_cxsz2, 14'd0});
            o_m[4] <= rnd42(-r_t4 + {{2{r_cxcz2[31]}}, r_cxcz2, 14'd0});
            o_m[5] <= r_e5;
            o_m[6] <= rnd42(-r_t6 + {{2{r_sxsz2[31]}}, r_sxsz2, 14'd0});
            o_m[7] <= rnd42(r_t7 + {{2{r_sxcz2[31]}}, r_sxcz2, 14'd0});
            o_m[8] <= r_e8;
        end
    end

endmodule

/* design/euler_xyz_rotation_matrix.sv */
// A request passes the CORDIC lane registers and merge stages A, B and output to the master side.
// Throughput: one request per cycle while not stalled; the 16-step CORDIC lanes are fully pipelined.
// The whole pipeline stalls only while a finished result is not taken.
// Reset (synchronous, active low) clears the valid bits; data registers are not reset.
module euler_xyz_rotation_matrix
    import exyz_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // angle_x [16:0], angle_y [33:17], angle_z [50:34], zero fill to 56 bits
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
    output logic [143:0] m_axis_tdata
);

    localparam int LAT = CORDIC_STEPS + 5;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    // The pipeline moves whenever the last stage is empty or being taken.
    assign w_en = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    t_sincos w_sc [NUM_LANES];
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        exyz_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (s_axis_tdata[l*ANGLE_W +: ANGLE_W]),
            .o_sc    (w_sc[l])
        );
    end

    t_trig w_m [9];
    exyz_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_scx   (w_sc[0]),
        .i_scy   (w_sc[1]),
        .i_scz   (w_sc[2]),
        .o_m     (w_m)
    );

    assign m_axis_tvalid = r_vld[LAT-1];
    for (genvar k = 0; k < 9; k++) begin : g_out
        assign m_axis_tdata[k*ENTRY_W +: ENTRY_W] = w_m[k];
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result lost while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stall without pending result");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) <= LAT)
        else $error("valid count overflow");

endmodule
